/* design/a64_dp_register_execute_32_unit_macros.svh */
// ----------------------------------------------------------------------------
// a64 dp execute assertion macros
// shared concurrent assertion forms, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef A64_DP_REGISTER_EXECUTE_32_UNIT_MACROS_SVH
`define A64_DP_REGISTER_EXECUTE_32_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// implication in the same cycle
`define A64DP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("a64dp assertion failed");

// implication in the next cycle
`define A64DP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("a64dp assertion failed");

`else

`define A64DP_ASSERT_IMPL(label, ante, cons)
`define A64DP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* design/a64dp_pkg.sv */
// ----------------------------------------------------------------------------
// a64dp_pkg
// shared types and constants of the 32-bit data-processing execute unit
// ----------------------------------------------------------------------------
`default_nettype none

package a64dp_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned LOAD_W      = 64;
  localparam int unsigned REG_IDX_W   = 5;
  localparam int unsigned REG_COUNT   = 32;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  localparam logic [2:0]           DP_CLASS  = 3'b101;
  localparam logic [3:0]           OPR_MUL   = 4'b1000;
  localparam logic [1:0]           SHIFT_LSL = 2'b00;
  localparam logic [1:0]           SHIFT_LSR = 2'b01;
  localparam logic [1:0]           SHIFT_ASR = 2'b10;
  localparam logic [1:0]           SHIFT_ROR = 2'b11;
  localparam logic [1:0]           LOGIC_AND  = 2'b00;
  localparam logic [1:0]           LOGIC_ORR  = 2'b01;
  localparam logic [1:0]           LOGIC_EOR  = 2'b10;
  localparam logic [1:0]           LOGIC_ANDS = 2'b11;
  localparam logic [REG_IDX_W-1:0] ZERO_REG  = 5'd31;

  typedef enum logic [2:0] {
    KIND_LOAD,
    KIND_ARITH,
    KIND_LOGIC,
    KIND_MUL,
    KIND_BAD
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic [REG_IDX_W-1:0]  rd;
    logic [REG_IDX_W-1:0]  rn;
    logic [REG_IDX_W-1:0]  rm;
    logic [REG_IDX_W-1:0]  ra;
    logic [1:0]            shk;
    logic [4:0]            amt;
    logic [1:0]            opc;
    logic                  invert;
    logic                  msub;
    logic [DATA_W-1:0]     load_value;
  } uop_t;

endpackage

`default_nettype wire

/* design/a64dp_in_if.sv */
// ----------------------------------------------------------------------------
// a64dp_in_if
// input channel: instruction or register preset word
// ----------------------------------------------------------------------------
`default_nettype none

interface a64dp_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] instruction;
  logic [4:0]  load_index;
  logic [63:0] load_value;

  modport source (output valid, op, instruction, load_index, load_value, input ready);
  modport sink   (input valid, op, instruction, load_index, load_value, output ready);
endinterface

`default_nettype wire

/* design/a64dp_out_if.sv */
// ----------------------------------------------------------------------------
// a64dp_out_if
// output channel: execution result word
// ----------------------------------------------------------------------------
`default_nettype none

interface a64dp_out_if;
  logic        valid;
  logic        ready;
  logic        wrote;
  logic [4:0]  dest_index;
  logic [31:0] result_value;
  logic [3:0]  nzcv;
  logic        illegal;

  modport source (output valid, wrote, dest_index, result_value, nzcv, illegal,
                  input ready);
  modport sink   (input valid, wrote, dest_index, result_value, nzcv, illegal,
                  output ready);
endinterface

`default_nettype wire

/* design/a64_dp_register_execute_32_unit.sv */
// ----------------------------------------------------------------------------
// a64_dp_register_execute_32_unit
// a64 32-bit data-processing (register) execute unit with register file
// ----------------------------------------------------------------------------
//  channel  dir  words
//  req      in   op, instruction, load_index, load_value
//  rsp      out  wrote, dest_index, result_value, nzcv, illegal
//
//  one word per cycle sustained while rsp takes words; a word goes from req to rsp
//  through decode into queue, operand read, execute into result register
//  rsp stalls back up through a two-entry queue before req drops ready
//  no clearing pass after reset: per-register valid bits read as zero
// ----------------------------------------------------------------------------
`default_nettype none

module a64_dp_register_execute_32_unit (
  input  wire logic clk,
  input  wire logic rst,
  a64dp_in_if.sink  req,
  a64dp_out_if.source rsp
);
  import a64dp_pkg::*;

  logic q_push;
  uop_t q_push_uop;
  logic q_full;
  logic q_valid;
  uop_t q_head;
  logic q_pop;

  a64dp_front u_front (
    .req    (req),
    .q_full (q_full),
    .q_push (q_push),
    .q_uop  (q_push_uop)
  );

  a64dp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_uop   (q_push_uop),
    .full       (q_full),
    .head_valid (q_valid),
    .head_uop   (q_head),
    .pop        (q_pop)
  );

  a64dp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_uop   (q_head),
    .q_pop   (q_pop),
    .rsp     (rsp)
  );

endmodule

`default_nettype wire

/* design/a64dp_front.sv */
// ----------------------------------------------------------------------------
// a64dp_front
// accepts input words and decodes them into micro-ops for the queue
// ----------------------------------------------------------------------------
`default_nettype none

module a64dp_front (
  a64dp_in_if.sink        req,
  input  wire logic       q_full,
  output logic            q_push,
  output a64dp_pkg::uop_t q_uop
);
  import a64dp_pkg::*;

  logic [1:0] opc;
  logic       m;
  logic [2:0] cls;
  logic [3:0] opr;
  logic [5:0] imm6;
  kind_t      kind;

  assign opc  = req.instruction[30:29];
  assign m    = req.instruction[28];
  assign cls  = req.instruction[27:25];
  assign opr  = req.instruction[24:21];
  assign imm6 = req.instruction[15:10];

  always_comb begin
    if (req.op) begin
      kind = KIND_LOAD;
    end else if (req.instruction[31] || cls != DP_CLASS) begin
      kind = KIND_BAD;
    end else if (!m && opr[3]) begin
      kind = (opr[0] || opr[2:1] == SHIFT_ROR || imm6[5]) ? KIND_BAD : KIND_ARITH;
    end else if (!m) begin
      kind = imm6[5] ? KIND_BAD : KIND_LOGIC;
    end else begin
      kind = (opr != OPR_MUL || opc != 2'b00) ? KIND_BAD : KIND_MUL;
    end
  end

  always_comb begin
    q_uop.kind       = kind;
    q_uop.rd         = req.op ? req.load_index : req.instruction[4:0];
    q_uop.rn         = req.instruction[9:5];
    q_uop.rm         = req.instruction[20:16];
    q_uop.ra         = imm6[4:0];
    q_uop.shk        = opr[2:1];
    q_uop.amt        = imm6[4:0];
    q_uop.opc        = opc;
    q_uop.invert     = opr[0];
    q_uop.msub       = imm6[5];
    q_uop.load_value = req.load_value[DATA_W-1:0];
  end

  assign req.ready = !q_full;
  assign q_push    = req.valid && !q_full;

endmodule

`default_nettype wire

/* design/a64dp_queue.sv */
// ----------------------------------------------------------------------------
// a64dp_queue
// two-entry micro-op queue between decode and execute
// ----------------------------------------------------------------------------
`default_nettype none

module a64dp_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire a64dp_pkg::uop_t push_uop,
  output logic                 full,
  output logic                 head_valid,
  output a64dp_pkg::uop_t      head_uop,
  input  wire logic            pop
);
  import a64dp_pkg::*;

  uop_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;

  assign full       = count == QCNT_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_uop   = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_uop;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* design/a64dp_back.sv */
// ----------------------------------------------------------------------------
// a64dp_back
// register read, execute, writeback, flags and result register
// ----------------------------------------------------------------------------
`default_nettype none

`include "a64_dp_register_execute_32_unit_macros.svh"

module a64dp_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_valid,
  input  wire a64dp_pkg::uop_t q_uop,
  output logic                 q_pop,
  a64dp_out_if.source          rsp
);
  import a64dp_pkg::*;

  // register file copies: one for rn/rm, one for ra
  logic [DATA_W-1:0] mem_a [REG_COUNT];
  logic [DATA_W-1:0] mem_b [REG_COUNT];
  logic [REG_COUNT-1:0] vld;

  logic              s2_valid;
  uop_t              s2_uop;
  logic [DATA_W-1:0] rn_val;
  logic [DATA_W-1:0] rm_val;
  logic [DATA_W-1:0] ra_val;
  logic [3:0]        flags;
  logic [3:0]        flags_next;

  logic              s2_fire;
  logic              s2_ready;
  logic              wr_en;
  logic [REG_IDX_W-1:0] wr_addr;

  logic [DATA_W-1:0]   shifted;
  logic [2*DATA_W-1:0] rot;
  logic [DATA_W-1:0]   b_op;
  logic [DATA_W:0]     sum;
  logic [DATA_W-1:0]   prod;
  logic [DATA_W-1:0]   res;
  logic                res_wrote;
  logic                res_bad;

  logic              out_valid;
  logic              out_wrote;
  logic [REG_IDX_W-1:0] out_dest;
  logic [DATA_W-1:0] out_value;
  logic [3:0]        out_nzcv;
  logic              out_illegal;

  assign s2_fire  = s2_valid && (!out_valid || rsp.ready);
  assign s2_ready = !s2_valid || s2_fire;
  assign q_pop    = q_valid && s2_ready;
  assign wr_en    = s2_fire && res_wrote;
  assign wr_addr  = s2_uop.rd;

  // operand read with bypass from the retiring word
  always_ff @(posedge clk) begin
    if (q_pop) begin
      s2_uop <= q_uop;
      rn_val <= (wr_en && wr_addr == q_uop.rn) ? res :
                (vld[q_uop.rn] ? mem_a[q_uop.rn] : '0);
      rm_val <= (wr_en && wr_addr == q_uop.rm) ? res :
                (vld[q_uop.rm] ? mem_a[q_uop.rm] : '0);
      ra_val <= (wr_en && wr_addr == q_uop.ra) ? res :
                (vld[q_uop.ra] ? mem_b[q_uop.ra] : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_a[wr_addr] <= res;
      mem_b[wr_addr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      s2_valid <= 1'b0;
      flags    <= '0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (s2_ready) begin
        s2_valid <= q_valid;
      end
      if (s2_fire) begin
        flags <= flags_next;
      end
    end
  end

  // shifter
  always_comb begin
    rot = {rm_val, rm_val} >> s2_uop.amt;
    case (s2_uop.shk)
      SHIFT_LSL: shifted = rm_val << s2_uop.amt;
      SHIFT_LSR: shifted = rm_val >> s2_uop.amt;
      SHIFT_ASR: shifted = DATA_W'($signed(rm_val) >>> s2_uop.amt);
      SHIFT_ROR: shifted = rot[DATA_W-1:0];
      default:   shifted = rm_val;
    endcase
  end

  assign prod = DATA_W'(rn_val * rm_val);

  always_comb begin
    b_op       = '0;
    sum        = '0;
    res        = '0;
    res_bad    = 1'b0;
    flags_next = flags;
    case (s2_uop.kind)
      KIND_LOAD: begin
        res = s2_uop.load_value;
      end
      KIND_ARITH: begin
        b_op = s2_uop.opc[1] ? ~shifted : shifted;
        sum  = {1'b0, rn_val} + {1'b0, b_op} + (DATA_W+1)'(s2_uop.opc[1]);
        res  = sum[DATA_W-1:0];
        if (s2_uop.opc[0]) begin
          flags_next = {res[DATA_W-1], res == '0, sum[DATA_W],
                        ~(rn_val[DATA_W-1] ^ b_op[DATA_W-1]) &
                        (rn_val[DATA_W-1] ^ res[DATA_W-1])};
        end
      end
      KIND_LOGIC: begin
        b_op = s2_uop.invert ? ~shifted : shifted;
        case (s2_uop.opc)
          LOGIC_AND: res = rn_val & b_op;
          LOGIC_ORR: res = rn_val | b_op;
          LOGIC_EOR: res = rn_val ^ b_op;
          LOGIC_ANDS: begin
            res        = rn_val & b_op;
            flags_next = {res[DATA_W-1], res == '0, 2'b00};
          end
          default: res = '0;
        endcase
      end
      KIND_MUL: begin
        res = s2_uop.msub ? ra_val - prod : ra_val + prod;
      end
      default: begin
        res_bad = 1'b1;
      end
    endcase
  end

  assign res_wrote = !res_bad && s2_uop.rd != ZERO_REG;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      out_wrote   <= res_wrote;
      out_dest    <= s2_uop.rd;
      out_value   <= res;
      out_nzcv    <= flags_next;
      out_illegal <= res_bad;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.wrote        = out_wrote;
  assign rsp.dest_index   = out_dest;
  assign rsp.result_value = out_value;
  assign rsp.nzcv         = out_nzcv;
  assign rsp.illegal      = out_illegal;

  `A64DP_ASSERT_IMPL(a_wrote_legal, rsp.valid, !(rsp.wrote && rsp.illegal))
  `A64DP_ASSERT_IMPL(a_bad_zero, rsp.valid && rsp.illegal, rsp.result_value == '0)
  `A64DP_ASSERT_NEXT(a_flags_hold, !s2_fire, $stable(flags))
  `A64DP_ASSERT_IMPL(a_no_zero_reg_write, wr_en, wr_addr != ZERO_REG)

endmodule

`default_nettype wire

/* tb/a64dp_tb_pkg.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// a64dp_tb_pkg
// word types and the execute predictor shared by the testbench
// ----------------------------------------------------------------------------
`default_nettype none

package a64dp_tb_pkg;
  import a64dp_pkg::*;

  localparam logic OP_EXEC = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  typedef struct packed {
    logic        op;
    logic [31:0] instruction;
    logic [4:0]  load_index;
    logic [63:0] load_value;
  } req_word_t;

  typedef struct packed {
    logic        wrote;
    logic [4:0]  dest_index;
    logic [31:0] result_value;
    logic [3:0]  nzcv;
    logic        illegal;
  } rsp_word_t;

  logic [63:0] regs_shadow [31];
  logic [3:0]  flags_shadow;

  function automatic void shadow_reset();
    for (int i = 0; i < 31; i++) regs_shadow[i] = '0;
    flags_shadow = '0;
  endfunction

  function automatic logic [31:0] read_reg(logic [4:0] idx);
    if (idx == ZERO_REG) return '0;
    return regs_shadow[idx][31:0];
  endfunction

  function automatic logic [31:0] shift_val(logic [31:0] v, logic [1:0] k, logic [4:0] s);
    logic [63:0] dbl;
    dbl = {v, v};
    case (k)
      SHIFT_LSL: return v << s;
      SHIFT_LSR: return v >> s;
      SHIFT_ASR: return $unsigned($signed(v) >>> s);
      default:   return dbl[s +: 32];
    endcase
  endfunction

  function automatic logic [3:0] nz_of(logic [31:0] r);
    return {r[31], r == 32'd0, 2'b00};
  endfunction

  function automatic rsp_word_t execute_word(req_word_t w);
    rsp_word_t   o;
    logic [31:0] ins, a, b, res;
    logic [32:0] sum;
    logic [1:0]  opc, shk;
    logic [3:0]  opr;
    logic [5:0]  imm6;
    logic        bad;
    ins  = w.instruction;
    opc  = ins[30:29];
    opr  = ins[24:21];
    imm6 = ins[15:10];
    shk  = opr[2:1];
    res  = '0;
    bad  = 1'b0;
    o    = '0;
    if (w.op == OP_LOAD) begin
      if (w.load_index != ZERO_REG) regs_shadow[w.load_index] = w.load_value;
      o.wrote        = w.load_index != ZERO_REG;
      o.dest_index   = w.load_index;
      o.result_value = w.load_value[31:0];
      o.nzcv         = flags_shadow;
      return o;
    end
    if (ins[31] || ins[27:25] != DP_CLASS) begin
      bad = 1'b1;
    end else if (!ins[28] && opr[3]) begin
      if (opr[0] || shk == SHIFT_ROR || imm6[5]) begin
        bad = 1'b1;
      end else begin
        a = read_reg(ins[9:5]);
        b = shift_val(read_reg(ins[20:16]), shk, imm6[4:0]);
        if (opc[1]) begin
          sum = {1'b0, a} + {1'b0, ~b} + 33'd1;
          res = sum[31:0];
          if (opc[0]) flags_shadow = nz_of(res) | {2'b00, a >= b, (a[31] ^ b[31]) & (a[31] ^ res[31])};
        end else begin
          sum = {1'b0, a} + {1'b0, b};
          res = sum[31:0];
          if (opc[0]) flags_shadow = nz_of(res) | {2'b00, sum[32], ~(a[31] ^ b[31]) & (a[31] ^ res[31])};
        end
      end
    end else if (!ins[28]) begin
      if (imm6[5]) begin
        bad = 1'b1;
      end else begin
        a = read_reg(ins[9:5]);
        b = shift_val(read_reg(ins[20:16]), shk, imm6[4:0]);
        if (opr[0]) b = ~b;
        case (opc)
          LOGIC_AND: res = a & b;
          LOGIC_ORR: res = a | b;
          LOGIC_EOR: res = a ^ b;
          default: begin
            res = a & b;
            flags_shadow = nz_of(res);
          end
        endcase
      end
    end else begin
      if (opr != OPR_MUL || opc != 2'b00) begin
        bad = 1'b1;
      end else begin
        a = read_reg(ins[9:5]) * read_reg(ins[20:16]);
        b = read_reg(imm6[4:0]);
        res = imm6[5] ? b - a : b + a;
      end
    end
    o.dest_index = ins[4:0];
    o.nzcv       = flags_shadow;
    if (bad) begin
      o.illegal = 1'b1;
      return o;
    end
    if (ins[4:0] != ZERO_REG) regs_shadow[ins[4:0]] = {32'd0, res};
    o.wrote        = ins[4:0] != ZERO_REG;
    o.result_value = res;
    o.nzcv         = flags_shadow;
    return o;
  endfunction
endpackage

`default_nettype wire

/* tb/a64_dp_register_execute_32_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// a64_dp_register_execute_32_unit_tb
// directed table then random instruction and preset words, scoreboarded
// against a behavioral predictor with random gaps on both channels
// ----------------------------------------------------------------------------
`default_nettype none

module a64_dp_register_execute_32_unit_tb;
  import a64dp_pkg::*;
  import a64dp_tb_pkg::*;

  typedef struct packed {
    req_word_t word;
    logic      has_exp;
    rsp_word_t exp;
  } table_row_t;

  logic clk;
  logic rst;
  a64dp_in_if  req ();
  a64dp_out_if rsp ();

  a64_dp_register_execute_32_unit dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  rsp_word_t  expected_rsp [$];
  rsp_word_t  typed_rsp [$];
  logic       typed_flag [$];
  table_row_t dir_rows [$];
  int         mismatches;
  logic       sending_done;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("a64_dp_register_execute_32_unit_tb: done, errors");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic logic [31:0] build(logic [2:0] top, logic m, logic [3:0] opr,
                                        logic [4:0] rm, logic [5:0] imm, logic [4:0] rn,
                                        logic [4:0] rd);
    return {top, m, DP_CLASS, opr, rm, imm, rn, rd};
  endfunction

  function automatic logic [4:0] rand_reg();
    return ($urandom_range(0, 9) == 0) ? ZERO_REG : 5'($urandom_range(0, 7));
  endfunction

  function automatic req_word_t rand_word();
    req_word_t w;
    int        sel;
    logic [1:0] opc;
    sel = $urandom_range(0, 99);
    w.op          = OP_EXEC;
    w.load_index  = 5'($urandom_range(0, 31));
    w.load_value  = {$urandom, $urandom};
    w.instruction = $urandom;
    opc = 2'($urandom);
    if (sel < 15) begin
      w.op = OP_LOAD;
      if ($urandom_range(0, 3) == 0) w.load_value = {$urandom, 1'b1, 31'($urandom)};
      else if ($urandom_range(0, 3) == 0) w.load_value[31:0] = '0;
    end else if (sel < 45) begin
      w.instruction = build({1'b0, opc}, 1'b0, {1'b1, 2'($urandom_range(0, 2)), 1'b0},
                            rand_reg(), 6'($urandom_range(0, 31)), rand_reg(), rand_reg());
    end else if (sel < 75) begin
      w.instruction = build({1'b0, opc}, 1'b0, {1'b0, 3'($urandom)},
                            rand_reg(), 6'($urandom_range(0, 31)), rand_reg(), rand_reg());
    end else if (sel < 90) begin
      w.instruction = build(3'b000, 1'b1, OPR_MUL, rand_reg(),
                            {1'($urandom), rand_reg()}, rand_reg(), rand_reg());
    end else if (sel < 95) begin
      w.instruction = build(3'($urandom), 1'($urandom), 4'($urandom), 5'($urandom),
                            6'($urandom), 5'($urandom), 5'($urandom));
    end
    return w;
  endfunction

  task automatic send_word(req_word_t w);
    repeat (gap_len()) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid       <= 1'b1;
    req.op          <= w.op;
    req.instruction <= w.instruction;
    req.load_index  <= w.load_index;
    req.load_value  <= w.load_value;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  task automatic add_row(req_word_t w, logic has, rsp_word_t e);
    table_row_t r;
    r.word = w; r.has_exp = has; r.exp = e;
    dir_rows.push_back(r);
  endtask

  task automatic fill_table();
    req_word_t w;
    rsp_word_t e;
    w = '0;
    e = '0;
    w.op = OP_LOAD; w.load_index = 5'd1; w.load_value = '1;
    e = '{1'b1, 5'd1, 32'hffffffff, 4'h0, 1'b0}; add_row(w, 1'b1, e);
    w.load_index = 5'd2; w.load_value = 64'h0000000180000000;
    add_row(w, 1'b0, e);
    w.load_index = ZERO_REG; w.load_value = 64'h123456789abcdef0;
    e = '{1'b0, ZERO_REG, 32'h9abcdef0, 4'h0, 1'b0}; add_row(w, 1'b1, e);
    w.load_index = 5'd30; w.load_value = 64'h7fffffff;
    add_row(w, 1'b0, e);
    w.op = OP_EXEC; w.load_index = '0; w.load_value = '0;
    w.instruction = 32'h80000000 | build(3'b000, 1'b0, 4'b1000, 5'd1, 6'd0, 5'd2, 5'd3);
    e = '{1'b0, 5'd3, 32'd0, 4'h0, 1'b1}; add_row(w, 1'b1, e);
    w.instruction = {build(3'b000, 1'b0, 4'b1000, 5'd1, 6'd0, 5'd2, 5'd3)} & ~32'h02000000;
    add_row(w, 1'b1, e);
    w.instruction = build(3'b000, 1'b0, 4'b1110, 5'd1, 6'd0, 5'd2, 5'd3);
    add_row(w, 1'b1, e);
    w.instruction = build(3'b000, 1'b0, 4'b1001, 5'd1, 6'd0, 5'd2, 5'd3);
    add_row(w, 1'b1, e);
    w.instruction = build(3'b000, 1'b0, 4'b1000, 5'd1, 6'd32, 5'd2, 5'd3);
    add_row(w, 1'b1, e);
    w.instruction = build(3'b001, 1'b0, 4'b0110, 5'd1, 6'd63, 5'd2, 5'd3);
    add_row(w, 1'b1, e);
    w.instruction = build(3'b001, 1'b1, OPR_MUL, 5'd1, 6'd0, 5'd2, 5'd3);
    add_row(w, 1'b1, e);
    w.instruction = build(3'b000, 1'b1, 4'b1001, 5'd1, 6'd0, 5'd2, 5'd3);
    add_row(w, 1'b1, e);
    w.instruction = build(3'b001, 1'b0, 4'b1000, 5'd1, 6'd0, 5'd30, 5'd4);
    add_row(w, 1'b0, e);
    w.instruction = build(3'b011, 1'b0, 4'b1000, 5'd30, 6'd0, 5'd2, 5'd5);
    add_row(w, 1'b0, e);
    w.instruction = build(3'b001, 1'b0, 4'b1010, 5'd1, 6'd31, 5'd2, ZERO_REG);
    add_row(w, 1'b0, e);
    w.instruction = build(3'b001, 1'b0, 4'b1100, 5'd2, 6'd31, 5'd1, 5'd6);
    add_row(w, 1'b0, e);
    for (int k = 0; k < 4; k++) begin
      w.instruction = build({1'b0, 2'(k)}, 1'b0, {1'b0, 2'(k), 1'b1}, 5'd2, 6'(k * 9),
                            5'd1, 5'(7 + k));
      add_row(w, 1'b0, e);
      w.instruction = build({1'b0, 2'(k)}, 1'b0, {1'b0, 2'(3 - k), 1'b0}, ZERO_REG, 6'd5,
                            5'd30, 5'(11 + k));
      add_row(w, 1'b0, e);
    end
    w.instruction = build(3'b000, 1'b1, OPR_MUL, 5'd1, 6'd30, 5'd2, 5'd15);
    add_row(w, 1'b0, e);
    w.instruction = build(3'b000, 1'b1, OPR_MUL, 5'd1, {1'b1, ZERO_REG}, 5'd30, 5'd16);
    add_row(w, 1'b0, e);
  endtask

  task automatic push_word(req_word_t w, logic has, rsp_word_t e);
    expected_rsp.push_back(execute_word(w));
    typed_rsp.push_back(e);
    typed_flag.push_back(has);
    send_word(w);
  endtask

  initial begin
    rsp_word_t none_exp;
    none_exp = '0;
    rst = 1'b1;
    sending_done = 1'b0;
    req.valid <= 1'b0;
    req.op <= OP_EXEC;
    req.instruction <= '0;
    req.load_index <= '0;
    req.load_value <= '0;
    shadow_reset();
    fill_table();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_rows[i]) push_word(dir_rows[i].word, dir_rows[i].has_exp, dir_rows[i].exp);
    for (int n = 0; n < 1200; n++) push_word(rand_word(), 1'b0, none_exp);
    req.valid <= 1'b0;
    sending_done = 1'b1;
  end

  initial begin
    int gap;
    rsp.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if ($urandom_range(0, 3) == 0) begin
        gap = gap_len();
        if (gap > 0) begin
          rsp.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    rsp_word_t got, exp, typed;
    logic      has;
    if (!rst && rsp.valid && rsp.ready) begin
      got = '{rsp.wrote, rsp.dest_index, rsp.result_value, rsp.nzcv, rsp.illegal};
      if (expected_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", got);
      end else begin
        exp   = expected_rsp.pop_front();
        typed = typed_rsp.pop_front();
        has   = typed_flag.pop_front();
        if (has && typed !== exp) begin
          mismatches++;
          if (mismatches <= 10) $display("table row disagrees: typed %h predicted %h", typed, exp);
        end
        if (got.wrote !== exp.wrote || got.dest_index !== exp.dest_index ||
            got.result_value !== exp.result_value || got.nzcv !== exp.nzcv ||
            got.illegal !== exp.illegal) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %h actual %h", exp, got);
        end
      end
    end
  end

  initial begin
    mismatches = 0;
    wait (sending_done);
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_rsp.size() == 0) begin
      $display("a64_dp_register_execute_32_unit_tb: done, clean");
    end else begin
      $display("a64_dp_register_execute_32_unit_tb: done, errors");
    end
    $finish;
  end
endmodule

`default_nettype wire
